// ----- design/balance_robot_cascade_controller_macros.svh -----
// Assertion macros shared by the balancing controller RTL.
`ifndef BALANCE_ROBOT_CASCADE_CONTROLLER_MACROS_SVH
`define BALANCE_ROBOT_CASCADE_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define BRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define BRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/brc_pkg.sv -----
// Types and constants shared by the balancing controller modules.
`timescale 1ns / 1ps
package brc_pkg;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_TILT_GAIN      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TILT_RATE_GAIN = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_GAIN     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BALANCE_ANGLE  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_LOW      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_MEDIUM   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_HIGH     = 3'd6;

  // Register reset values
  localparam logic signed [15:0] TILT_GAIN_RST      = -16'sd5243;
  localparam logic signed [15:0] TILT_RATE_GAIN_RST = 16'sd61;
  localparam logic signed [15:0] SPEED_GAIN_RST     = -16'sd6881;

  // Remote command letters
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_B = 8'h42;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_D = 8'h44;
  localparam logic [7:0] CHAR_E = 8'h45;
  localparam logic [7:0] CHAR_F = 8'h46;
  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_X = 8'h58;
  localparam logic [7:0] CHAR_Y = 8'h59;
  localparam logic [7:0] CHAR_Z = 8'h5A;

  // Mode codes
  localparam logic [1:0] DRIVE_STOP     = 2'd0;
  localparam logic [1:0] DRIVE_FORWARD  = 2'd1;
  localparam logic [1:0] DRIVE_BACKWARD = 2'd2;
  localparam logic [1:0] TURN_STRAIGHT  = 2'd0;
  localparam logic [1:0] TURN_LEFT      = 2'd1;
  localparam logic [1:0] TURN_RIGHT     = 2'd2;
  localparam logic [1:0] LEVEL_LOW      = 2'd0;
  localparam logic [1:0] LEVEL_MEDIUM   = 2'd1;
  localparam logic [1:0] LEVEL_HIGH     = 2'd2;

  // Fixed-point constants: fall limit is 90 degrees in Q8.7, filter weights in Q0.16
  localparam logic signed [15:0] FALL_LIMIT = 16'sd11520;
  localparam logic signed [15:0] COEF_OLD   = 16'sd19661;
  localparam longint COEF_NEW   = 45875;
  localparam longint TURN_LEVEL = 20;
  localparam logic signed [47:0] TURN_STEP  = 48'(COEF_NEW * TURN_LEVEL * 65536);
  localparam logic signed [47:0] ROUND_HALF = 48'sd32768;

  // Datapath step codes issued by the controller
  localparam logic [2:0] OP_NONE     = 3'd0;
  localparam logic [2:0] OP_CAPTURE  = 3'd1;
  localparam logic [2:0] OP_MUL_SPD  = 3'd2;
  localparam logic [2:0] OP_MUL_RATE = 3'd3;
  localparam logic [2:0] OP_MUL_TILT = 3'd4;
  localparam logic [2:0] OP_MUL_TURN = 3'd5;
  localparam logic [2:0] OP_FILTER   = 3'd6;
  localparam logic [2:0] OP_EMIT     = 3'd7;

  // Input request payload
  typedef struct packed {
    logic              cmd;
    logic [7:0]        first_byte;
    logic [7:0]        second_byte;
    logic signed [15:0] roll_angle;
    logic signed [15:0] gyro_rate;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
  } in_req_t;

  // Output result payload
  typedef struct packed {
    logic signed [15:0] left_drive;
    logic signed [15:0] right_drive;
    logic              fallen;
  } out_rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic [2:0] op;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic fallen;
    logic out_ready;
  } sts_t;

endpackage

// ----- design/balance_robot_cascade_controller.sv -----
// A tick request steps through the speed, rate, tilt, turn, filter and emit states, or only
// speed and emit when it has fallen; four products share one multiplier.
// A remote command request is taken while idle, leaves the sequencer idle and gives no result.
// A finished result waits in the output register; the next request is taken meanwhile.
// Reset (asynchronous, active low) restores register defaults, stop/straight/low modes
// and a zero turn filter.
`timescale 1ns / 1ps
`include "balance_robot_cascade_controller_macros.svh"
module balance_robot_cascade_controller #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  brc_pkg::in_req_t                  in_req_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output brc_pkg::out_rsp_t                 out_rsp_o,
  input  logic                              cfg_we_i,
  input  logic [brc_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [brc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  brc_pkg::ctl_t ctl;
  brc_pkg::sts_t sts;

  // Step sequencer.
  brc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_req_i.cmd),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // Arithmetic and state.
  brc_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  // Checks on the sequencing.
  `BRC_ASSERT_NEXT(a_cmd_one_cycle, in_valid_i && !in_stall_o && !in_req_i.cmd, !in_stall_o, "command request did not return to idle")
  `BRC_ASSERT_NEXT(a_tick_busy, in_valid_i && !in_stall_o && in_req_i.cmd, in_stall_o, "tick request did not start the sequence")
  `BRC_ASSERT_NOW(a_emit_room, ctl.op == brc_pkg::OP_EMIT, sts.out_ready, "result loaded over a waiting result")
  `BRC_ASSERT_NOW(a_fallen_zero, out_valid_o && out_rsp_o.fallen, out_rsp_o.left_drive == 16'sd0 && out_rsp_o.right_drive == 16'sd0, "fallen result with nonzero drive")

endmodule

// ----- design/brc_ctrl.sv -----
// Sequencer for the balancing controller: steps one request through the shared multiplier.
`timescale 1ns / 1ps
module brc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_cmd_i,
  output logic           in_stall_o,
  input  brc_pkg::sts_t  sts_i,
  output brc_pkg::ctl_t  ctl_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SPEED  = 3'd1;
  localparam logic [2:0] ST_RATE   = 3'd2;
  localparam logic [2:0] ST_TILT   = 3'd3;
  localparam logic [2:0] ST_TURN   = 3'd4;
  localparam logic [2:0] ST_FILTER = 3'd5;
  localparam logic [2:0] ST_EMIT   = 3'd6;

  logic [2:0] state_q, state_d;

  // Requests are taken only while idle.
  assign in_stall_o = (state_q != ST_IDLE);

  // Next state and step command.
  always_comb begin
    state_d   = state_q;
    ctl_o.op  = brc_pkg::OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.op = brc_pkg::OP_CAPTURE;
          if (in_cmd_i) begin
            state_d = ST_SPEED;
          end
        end
      end
      ST_SPEED: begin
        if (sts_i.fallen) begin
          state_d = ST_EMIT;
        end else begin
          ctl_o.op = brc_pkg::OP_MUL_SPD;
          state_d  = ST_RATE;
        end
      end
      ST_RATE: begin
        ctl_o.op = brc_pkg::OP_MUL_RATE;
        state_d  = ST_TILT;
      end
      ST_TILT: begin
        ctl_o.op = brc_pkg::OP_MUL_TILT;
        state_d  = ST_TURN;
      end
      ST_TURN: begin
        ctl_o.op = brc_pkg::OP_MUL_TURN;
        state_d  = ST_FILTER;
      end
      ST_FILTER: begin
        ctl_o.op = brc_pkg::OP_FILTER;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_ready) begin
          ctl_o.op = brc_pkg::OP_EMIT;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/brc_datapath.sv -----
// Datapath of the balancing controller: registers, remote decode, shared multiplier, output.
`timescale 1ns / 1ps
module brc_datapath #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  brc_pkg::in_req_t                  in_req_i,
  input  logic                              cfg_we_i,
  input  logic [brc_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [brc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  brc_pkg::ctl_t                     ctl_i,
  output brc_pkg::sts_t                     sts_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output brc_pkg::out_rsp_t                 out_rsp_o
);

  // Saturation bounds, held in a width that covers every supported DATA_WIDTH.
  localparam int SAT_W = 34;
  localparam logic signed [SAT_W-1:0] SAT_HI =
    SAT_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);

  // Configuration registers
  logic signed [15:0] tilt_gain_q, tilt_rate_gain_q, speed_gain_q, balance_angle_q;
  logic signed [15:0] speed_low_q, speed_medium_q, speed_high_q;

  // Remote modes and turn filter state
  logic [1:0] drive_mode_q, drive_mode_d;
  logic [1:0] turn_mode_q, turn_mode_d;
  logic [1:0] speed_select_q, speed_select_d;
  logic signed [23:0] turn_filter_q;

  // Working registers
  logic signed [17:0] e_q;
  logic signed [15:0] roll_q, gyro_q;
  logic               fallen_q;
  logic signed [31:0] err_q;
  logic signed [47:0] prod_q, acc_q;
  logic signed [28:0] v_q;

  // Output register
  logic              out_valid_q;
  brc_pkg::out_rsp_t out_rsp_q;

  // Combinational intermediates
  logic signed [15:0] level;
  logic signed [16:0] starget;
  logic signed [17:0] e_d;
  logic               fallen_d;
  logic signed [15:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [47:0] mul_p;
  logic signed [31:0] err_d;
  logic signed [47:0] turn_term;
  logic signed [47:0] filt_sum;
  logic signed [24:0] t_sum;
  logic signed [8:0]  t_val;
  logic signed [SAT_W-1:0] left_sum, right_sum;
  logic signed [SAT_W-1:0] left_sat, right_sat;
  logic capture_tick;

  assign capture_tick = (ctl_i.op == brc_pkg::OP_CAPTURE) && in_req_i.cmd;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tilt_gain_q      <= brc_pkg::TILT_GAIN_RST;
      tilt_rate_gain_q <= brc_pkg::TILT_RATE_GAIN_RST;
      speed_gain_q     <= brc_pkg::SPEED_GAIN_RST;
      balance_angle_q  <= '0;
      speed_low_q      <= '0;
      speed_medium_q   <= '0;
      speed_high_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        brc_pkg::REG_TILT_GAIN:      tilt_gain_q      <= $signed(cfg_data_i);
        brc_pkg::REG_TILT_RATE_GAIN: tilt_rate_gain_q <= $signed(cfg_data_i);
        brc_pkg::REG_SPEED_GAIN:     speed_gain_q     <= $signed(cfg_data_i);
        brc_pkg::REG_BALANCE_ANGLE:  balance_angle_q  <= $signed(cfg_data_i);
        brc_pkg::REG_SPEED_LOW:      speed_low_q      <= $signed(cfg_data_i);
        brc_pkg::REG_SPEED_MEDIUM:   speed_medium_q   <= $signed(cfg_data_i);
        brc_pkg::REG_SPEED_HIGH:     speed_high_q     <= $signed(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  // Remote decode: the tests run in order and a later match overrides an earlier one.
  always_comb begin
    drive_mode_d   = drive_mode_q;
    turn_mode_d    = turn_mode_q;
    speed_select_d = speed_select_q;
    if ((ctl_i.op == brc_pkg::OP_CAPTURE) && !in_req_i.cmd) begin
      if (in_req_i.first_byte == brc_pkg::CHAR_A) drive_mode_d = brc_pkg::DRIVE_FORWARD;
      if ((in_req_i.first_byte == brc_pkg::CHAR_Z) ||
          (in_req_i.second_byte == brc_pkg::CHAR_Z)) drive_mode_d = brc_pkg::DRIVE_STOP;
      if (in_req_i.first_byte == brc_pkg::CHAR_B) drive_mode_d = brc_pkg::DRIVE_BACKWARD;
      if (in_req_i.first_byte == brc_pkg::CHAR_C) turn_mode_d = brc_pkg::TURN_LEFT;
      if (in_req_i.first_byte == brc_pkg::CHAR_D) turn_mode_d = brc_pkg::TURN_RIGHT;
      if ((in_req_i.first_byte == brc_pkg::CHAR_Y) ||
          (in_req_i.second_byte == brc_pkg::CHAR_Y)) turn_mode_d = brc_pkg::TURN_STRAIGHT;
      if (in_req_i.first_byte == brc_pkg::CHAR_X) begin
        drive_mode_d = brc_pkg::DRIVE_STOP;
        turn_mode_d  = brc_pkg::TURN_STRAIGHT;
      end
      if (in_req_i.first_byte == brc_pkg::CHAR_E) speed_select_d = brc_pkg::LEVEL_LOW;
      if (in_req_i.first_byte == brc_pkg::CHAR_F) speed_select_d = brc_pkg::LEVEL_MEDIUM;
      if (in_req_i.first_byte == brc_pkg::CHAR_G) speed_select_d = brc_pkg::LEVEL_HIGH;
    end
  end

  // Speed error and fall test, evaluated as the tick is captured.
  always_comb begin
    case (speed_select_q)
      brc_pkg::LEVEL_MEDIUM: level = speed_medium_q;
      brc_pkg::LEVEL_HIGH:   level = speed_high_q;
      default:               level = speed_low_q;
    endcase
    case (drive_mode_q)
      brc_pkg::DRIVE_FORWARD:  starget = 17'(level);
      brc_pkg::DRIVE_BACKWARD: starget = -17'(level);
      default:                 starget = '0;
    endcase
    e_d = 18'(in_req_i.left_speed) + 18'(in_req_i.right_speed) - 18'(starget);
    fallen_d = !((in_req_i.roll_angle < brc_pkg::FALL_LIMIT) &&
                 (in_req_i.roll_angle > -brc_pkg::FALL_LIMIT));
  end

  // Shared multiplier operand selection.
  always_comb begin
    case (ctl_i.op)
      brc_pkg::OP_MUL_SPD: begin
        mul_a = speed_gain_q;
        mul_b = 32'(e_q);
      end
      brc_pkg::OP_MUL_RATE: begin
        mul_a = tilt_rate_gain_q;
        mul_b = 32'(gyro_q);
      end
      brc_pkg::OP_MUL_TILT: begin
        mul_a = tilt_gain_q;
        mul_b = err_q;
      end
      brc_pkg::OP_MUL_TURN: begin
        mul_a = brc_pkg::COEF_OLD;
        mul_b = 32'(turn_filter_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = 48'(mul_a) * 48'(mul_b);
  end

  // Angle error: roll minus the speed-shifted target, the product taken floor-divided by 32.
  assign err_d = 32'(roll_q) - 32'(balance_angle_q) - $signed(prod_q[36:5]);

  // Turn filter update with rounding.
  always_comb begin
    case (turn_mode_q)
      brc_pkg::TURN_LEFT:  turn_term = -brc_pkg::TURN_STEP;
      brc_pkg::TURN_RIGHT: turn_term = brc_pkg::TURN_STEP;
      default:             turn_term = '0;
    endcase
    filt_sum = prod_q + turn_term + brc_pkg::ROUND_HALF;
  end

  // Rounded turn term, drive sums and saturation.
  always_comb begin
    t_sum     = 25'(turn_filter_q) + 25'(brc_pkg::ROUND_HALF);
    t_val     = t_sum[24:16];
    left_sum  = SAT_W'(v_q) - SAT_W'(t_val);
    right_sum = SAT_W'(v_q) + SAT_W'(t_val);
    if (left_sum > SAT_HI) begin
      left_sat = SAT_HI;
    end else if (left_sum < SAT_LO) begin
      left_sat = SAT_LO;
    end else begin
      left_sat = left_sum;
    end
    if (right_sum > SAT_HI) begin
      right_sat = SAT_HI;
    end else if (right_sum < SAT_LO) begin
      right_sat = SAT_LO;
    end else begin
      right_sat = right_sum;
    end
  end

  // Mode and filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_mode_q   <= brc_pkg::DRIVE_STOP;
      turn_mode_q    <= brc_pkg::TURN_STRAIGHT;
      speed_select_q <= brc_pkg::LEVEL_LOW;
      turn_filter_q  <= '0;
    end else begin
      drive_mode_q   <= drive_mode_d;
      turn_mode_q    <= turn_mode_d;
      speed_select_q <= speed_select_d;
      if (ctl_i.op == brc_pkg::OP_FILTER) begin
        turn_filter_q <= filt_sum[39:16];
      end
    end
  end

  // Working registers, one step at a time.
  always_ff @(posedge clk_i) begin
    if (capture_tick) begin
      e_q      <= e_d;
      roll_q   <= in_req_i.roll_angle;
      gyro_q   <= in_req_i.gyro_rate;
      fallen_q <= fallen_d;
    end
    if ((ctl_i.op == brc_pkg::OP_MUL_SPD) || (ctl_i.op == brc_pkg::OP_MUL_RATE) ||
        (ctl_i.op == brc_pkg::OP_MUL_TILT) || (ctl_i.op == brc_pkg::OP_MUL_TURN)) begin
      prod_q <= mul_p;
    end
    if (ctl_i.op == brc_pkg::OP_MUL_RATE) begin
      err_q <= err_d;
    end
    if (ctl_i.op == brc_pkg::OP_MUL_TILT) begin
      acc_q <= prod_q <<< 7;
    end
    if (ctl_i.op == brc_pkg::OP_MUL_TURN) begin
      acc_q <= acc_q + prod_q;
    end
    if (ctl_i.op == brc_pkg::OP_FILTER) begin
      v_q <= acc_q[47:19];
    end
  end

  // Output register: loads a result and holds it until the far side takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.op == brc_pkg::OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.op == brc_pkg::OP_EMIT) begin
      if (fallen_q) begin
        out_rsp_q.left_drive  <= '0;
        out_rsp_q.right_drive <= '0;
        out_rsp_q.fallen      <= 1'b1;
      end else begin
        out_rsp_q.left_drive  <= left_sat[15:0];
        out_rsp_q.right_drive <= right_sat[15:0];
        out_rsp_q.fallen      <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_rsp_o       = out_rsp_q;
  assign sts_o.fallen    = fallen_q;
  assign sts_o.out_ready = !out_valid_q || !out_stall_i;

endmodule
